// ===== sv/psu_pkg.sv =====
package psu_pkg;

  // line store geometry
  localparam int unsigned LINE_BYTES = 8192;
  localparam int unsigned COL_W      = $clog2(LINE_BYTES);
  localparam int unsigned LEN_W      = COL_W + 1;

  // configuration field widths
  localparam int unsigned WIDTH_W  = 12;
  localparam int unsigned HEIGHT_W = 16;
  localparam int unsigned BPP_W    = 3;
  localparam int unsigned PROD_W   = WIDTH_W + BPP_W;
  localparam int unsigned CFG_W    = HEIGHT_W;
  localparam int unsigned CFG_IDX_W = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PIXEL = 2'd2;

  // largest legal filter code
  localparam logic [7:0] FILT_MAX_CODE = 8'd4;

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filter_e;

  // per-word control carried from the accept stage into reconstruction
  typedef struct packed {
    filter_e            filter;
    logic               flagged;
    logic               last_byte;
    logic               last_row;
    logic               left_ok;
    logic               upper_ok;
    logic               above_ok;
    logic [1:0]         bpp_sel;
    logic [COL_W-1:0]   col;
  } ctl_t;

endpackage

// ===== sv/psu_line_ram.sv =====
module psu_line_ram (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [psu_pkg::COL_W-1:0] waddr_i,
  input  logic [7:0]               wdata_i,
  input  logic                     re_i,
  input  logic [psu_pkg::COL_W-1:0] raddr_i,
  output logic [7:0]               rdata_o
);

  logic [7:0] mem [psu_pkg::LINE_BYTES];
  logic [7:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/psu_recon.sv =====
module psu_recon (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          shift_i,
  input  psu_pkg::ctl_t ctl_i,
  input  logic [7:0]    data_i,
  input  logic [7:0]    above_raw_i,
  output logic [7:0]    val_o
);

  logic [7:0] left_q [4];
  logic [7:0] upleft_q [4];
  logic [7:0] a, b, c, pred;
  logic [8:0] ab_sum;
  logic signed [10:0] pa, pb, pc;
  logic [10:0] abs_a, abs_b, abs_c;

  // neighbor selection
  always_comb begin
    a = ctl_i.left_ok ? left_q[ctl_i.bpp_sel] : 8'd0;
    c = (ctl_i.left_ok && ctl_i.upper_ok) ? upleft_q[ctl_i.bpp_sel] : 8'd0;
    b = ctl_i.above_ok ? above_raw_i : 8'd0;
  end

  // paeth distances
  always_comb begin
    ab_sum = {1'b0, a} + {1'b0, b};
    pa = $signed({3'b000, b}) - $signed({3'b000, c});
    pb = $signed({3'b000, a}) - $signed({3'b000, c});
    pc = $signed({2'b00, ab_sum}) - $signed({2'b00, c, 1'b0});
    abs_a = pa[10] ? 11'(-pa) : 11'(pa);
    abs_b = pb[10] ? 11'(-pb) : 11'(pb);
    abs_c = pc[10] ? 11'(-pc) : 11'(pc);
  end

  // predictor
  always_comb begin
    case (ctl_i.filter)
      psu_pkg::FILT_SUB:   pred = a;
      psu_pkg::FILT_UP:    pred = b;
      psu_pkg::FILT_AVG:   pred = ab_sum[8:1];
      psu_pkg::FILT_PAETH: begin
        if (abs_a <= abs_b && abs_a <= abs_c) begin
          pred = a;
        end else if (abs_b <= abs_c) begin
          pred = b;
        end else begin
          pred = c;
        end
      end
      default:             pred = 8'd0;
    endcase
  end

  assign val_o = data_i + pred;

  // history of reconstructed and above bytes, newest first
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        left_q[i]   <= 8'd0;
        upleft_q[i] <= 8'd0;
      end
    end else if (shift_i) begin
      for (int i = 3; i > 0; i--) begin
        left_q[i]   <= left_q[i-1];
        upleft_q[i] <= upleft_q[i-1];
      end
      left_q[0]   <= val_o;
      upleft_q[0] <= b;
    end
  end

endmodule

// ===== sv/png_scanline_unfilter.sv =====
// PNG scanline filter reconstruction, 8-bit non-interlaced images.
// Input channel (in_valid_i/in_ready_o, stream_byte_i) takes one word of the
// inflated stream per cycle while in_ready_o is high: a filter type word at the
// head of each row, then width * bytes-per-pixel filtered data words.
// Output channel (out_valid_o/out_ready_i) gives one reconstructed word per
// data word with row_end_o, image_end_o and bad_filter_o; filter words give
// nothing. A filter type above 4 reconstructs as None and flags the row.
// A data word is registered with its line store read into the reconstruction
// stage, then reconstructed into the output register.
// Throughput: one word per cycle unless the receiver stalls, set by the separate
// read and write ports of the line store and the reconstruct/write-back stage;
// the left neighbor of the next word comes straight from the history registers.
// When the receiver stalls, the output register holds and the stage behind it
// keeps one more word, after which in_ready_o drops.
// Reset: registers return to width 1, height 1, 4 bytes per pixel; the row
// state waits for a filter word. The line store is not swept: a fill count
// marks the written prefix and unwritten bytes read as zero, so the block
// takes words from the first cycle after reset.
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect at once
// and are meant for idle periods only.
module png_scanline_unfilter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [psu_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [psu_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    stream_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    pixel_byte_o,
  output logic                          row_end_o,
  output logic                          image_end_o,
  output logic                          bad_filter_o
);

  localparam int unsigned COL_W = psu_pkg::COL_W;
  localparam int unsigned LEN_W = psu_pkg::LEN_W;
  localparam int unsigned HGT_W = psu_pkg::HEIGHT_W;

  // configuration registers
  logic [psu_pkg::WIDTH_W-1:0]  width_q;
  logic [HGT_W-1:0]             height_q;
  logic [psu_pkg::BPP_W-1:0]    bpp_q;

  // row state
  logic                 awaiting_q;
  psu_pkg::filter_e     filter_q;
  logic                 flagged_q;
  logic [COL_W-1:0]     byte_col_q;
  logic [HGT_W-1:0]     row_idx_q;
  logic [LEN_W-1:0]     fill_q;

  // reconstruction stage
  logic                 s1_valid_q;
  psu_pkg::ctl_t        s1_ctl_q;
  logic [7:0]           s1_data_q;

  // output register
  logic                 out_valid_q;
  logic [7:0]           out_pixel_q;
  logic                 out_row_end_q, out_image_end_q, out_bad_q;

  logic                 advance, accept, accept_data;
  logic [1:0]           bpp_sel;
  logic [psu_pkg::BPP_W-1:0] bpp_eff;
  logic [psu_pkg::WIDTH_W-1:0] width_eff;
  logic [HGT_W-1:0]     height_eff;
  logic [psu_pkg::PROD_W-1:0] row_prod;
  logic [LEN_W-1:0]     row_len, col_next;
  logic [COL_W-1:0]     col;
  logic [HGT_W:0]       row_next;
  logic                 last_byte, last_row;
  psu_pkg::ctl_t        ctl_d;
  logic [7:0]           above_raw, val;

  // handshake
  assign advance     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || advance;
  assign accept      = in_valid_i && in_ready_o;
  assign accept_data = accept && !awaiting_q;

  // effective geometry
  always_comb begin
    if (bpp_q == '0) begin
      bpp_sel = 2'd0;
    end else if (bpp_q > 3'd4) begin
      bpp_sel = 2'd3;
    end else begin
      bpp_sel = 2'(bpp_q - 3'd1);
    end
    bpp_eff    = {1'b0, bpp_sel} + 3'd1;
    width_eff  = (width_q == '0) ? psu_pkg::WIDTH_W'(1) : width_q;
    height_eff = (height_q == '0) ? HGT_W'(1) : height_q;
    row_prod   = psu_pkg::PROD_W'(width_eff) * psu_pkg::PROD_W'(bpp_eff);
    row_len    = (row_prod > psu_pkg::PROD_W'(psu_pkg::LINE_BYTES)) ?
                 LEN_W'(psu_pkg::LINE_BYTES) : LEN_W'(row_prod);
  end

  // column and row ends
  always_comb begin
    col       = ({1'b0, byte_col_q} >= row_len) ? COL_W'(row_len - LEN_W'(1)) : byte_col_q;
    col_next  = {1'b0, byte_col_q} + LEN_W'(1);
    last_byte = col_next >= row_len;
    row_next  = {1'b0, row_idx_q} + (HGT_W+1)'(1);
    last_row  = last_byte && (row_next >= {1'b0, height_eff});
  end

  // control for the next data word
  always_comb begin
    ctl_d.filter    = filter_q;
    ctl_d.flagged   = flagged_q;
    ctl_d.last_byte = last_byte;
    ctl_d.last_row  = last_row;
    ctl_d.left_ok   = col >= COL_W'(bpp_eff);
    ctl_d.upper_ok  = row_idx_q != '0;
    ctl_d.above_ok  = (row_idx_q != '0) && ({1'b0, col} < fill_q);
    ctl_d.bpp_sel   = bpp_sel;
    ctl_d.col       = col;
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= psu_pkg::WIDTH_W'(1);
      height_q <= HGT_W'(1);
      bpp_q    <= psu_pkg::BPP_W'(4);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        psu_pkg::REG_IMAGE_WIDTH:     width_q  <= cfg_data_i[psu_pkg::WIDTH_W-1:0];
        psu_pkg::REG_IMAGE_HEIGHT:    height_q <= cfg_data_i[HGT_W-1:0];
        psu_pkg::REG_BYTES_PER_PIXEL: bpp_q    <= cfg_data_i[psu_pkg::BPP_W-1:0];
        default: ;
      endcase
    end
  end

  // row and column tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaiting_q <= 1'b1;
      filter_q   <= psu_pkg::FILT_NONE;
      flagged_q  <= 1'b0;
      byte_col_q <= '0;
      row_idx_q  <= '0;
      fill_q     <= '0;
    end else if (accept) begin
      if (awaiting_q) begin
        awaiting_q <= 1'b0;
        byte_col_q <= '0;
        if (stream_byte_i > psu_pkg::FILT_MAX_CODE) begin
          filter_q  <= psu_pkg::FILT_NONE;
          flagged_q <= 1'b1;
        end else begin
          filter_q  <= psu_pkg::filter_e'(stream_byte_i[2:0]);
          flagged_q <= 1'b0;
        end
      end else begin
        if ({1'b0, col} >= fill_q) begin
          fill_q <= {1'b0, col} + LEN_W'(1);
        end
        if (last_byte) begin
          byte_col_q <= '0;
          awaiting_q <= 1'b1;
          row_idx_q  <= last_row ? '0 : row_next[HGT_W-1:0];
        end else begin
          byte_col_q <= col_next[COL_W-1:0];
        end
      end
    end
  end

  // reconstruction stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= accept_data;
    end
  end

  // reconstruction stage payload
  always_ff @(posedge clk_i) begin
    if (accept_data) begin
      s1_ctl_q  <= ctl_d;
      s1_data_q <= stream_byte_i;
    end
  end

  psu_line_ram u_line_ram (
    .clk_i   (clk_i),
    .we_i    (advance),
    .waddr_i (s1_ctl_q.col),
    .wdata_i (val),
    .re_i    (accept_data),
    .raddr_i (col),
    .rdata_o (above_raw)
  );

  psu_recon u_recon (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .shift_i     (advance),
    .ctl_i       (s1_ctl_q),
    .data_i      (s1_data_q),
    .above_raw_i (above_raw),
    .val_o       (val)
  );

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_pixel_q     <= val;
      out_row_end_q   <= s1_ctl_q.last_byte;
      out_image_end_q <= s1_ctl_q.last_row;
      out_bad_q       <= s1_ctl_q.flagged;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_byte_o = out_pixel_q;
  assign row_end_o    = out_row_end_q;
  assign image_end_o  = out_image_end_q;
  assign bad_filter_o = out_bad_q;

  // image end only on a row end
  a_image_end_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!image_end_o || row_end_o))
    else $error("image end without row end");

  // filter word always starts at column zero
  a_await_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    awaiting_q |-> (byte_col_q == '0))
    else $error("awaiting filter word with nonzero column");

  // fill count never passes the line store
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= LEN_W'(psu_pkg::LINE_BYTES))
    else $error("fill count beyond line store");

  // first row of an image never uses the line store
  a_first_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_data && (row_idx_q == '0)) |=> !s1_ctl_q.above_ok)
    else $error("line store used on first row");

  // a held result is not overwritten
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !advance)
    else $error("output overwritten while stalled");

endmodule

// ===== bench/png_scanline_unfilter_test.sv =====
`timescale 1ns / 100ps

module png_scanline_unfilter_test;
  import psu_pkg::*;

  localparam int RUN_LIMIT_NS   = 2_000_000;
  localparam int SETTLE_CYCLES  = 6;
  localparam int RX_HOLD_CYCLES = 250;
  localparam int RANDOM_WORDS   = 950;
  localparam int MAX_REPORTS    = 10;

  // one reconstructed word as seen on the output channel
  typedef struct packed {
    logic [7:0] pixel;
    logic       row_end;
    logic       image_end;
    logic       bad;
  } pix_word_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [7:0]           stream_byte;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [7:0]           pixel_byte;
  logic                 row_end;
  logic                 image_end;
  logic                 bad_filter;

  // unfilter state kept by the bench
  logic [7:0]          row_above [LINE_BYTES];
  logic [7:0]          recent_px [4];
  logic [7:0]          recent_up [4];
  int unsigned         col_pos;
  int unsigned         row_pos;
  filter_e             row_kind;
  logic                want_filter;
  logic                row_bad;
  logic [WIDTH_W-1:0]  cur_width;
  logic [HEIGHT_W-1:0] cur_height;
  logic [BPP_W-1:0]    cur_bpp;
  pix_word_t           pending_pixels[$];

  // run control and statistics
  logic      sender_idles   = 1'b1;
  logic      receiver_idles = 1'b1;
  logic      rx_hold_req    = 1'b0;
  int        rx_hold_left   = 0;
  int        mismatches     = 0;
  int        words_in       = 0;
  int        pixels_checked = 0;
  int        rows_done      = 0;
  int        images_done    = 0;
  int        bad_rows       = 0;
  pix_word_t got_word;
  pix_word_t want_word;

  png_scanline_unfilter u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .stream_byte_i (stream_byte),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .pixel_byte_o  (pixel_byte),
    .row_end_o     (row_end),
    .image_end_o   (image_end),
    .bad_filter_o  (bad_filter)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // paeth predictor: nearest of left, above, upper-left to a + b - c
  function automatic logic [7:0] paeth_pick(logic [7:0] a, logic [7:0] b, logic [7:0] c);
    int p;
    int pa;
    int pb;
    int pc;
    p  = int'(a) + int'(b) - int'(c);
    pa = p - int'(a);
    pb = p - int'(b);
    pc = p - int'(c);
    if (pa < 0) pa = -pa;
    if (pb < 0) pb = -pb;
    if (pc < 0) pc = -pc;
    if (pa <= pb && pa <= pc) return a;
    if (pb <= pc) return b;
    return c;
  endfunction

  function automatic void clear_unfilter_state();
    int i;
    for (i = 0; i < LINE_BYTES; i++) row_above[i] = 8'd0;
    for (i = 0; i < 4; i++) begin
      recent_px[i] = 8'd0;
      recent_up[i] = 8'd0;
    end
    col_pos     = 0;
    row_pos     = 0;
    row_kind    = FILT_NONE;
    want_filter = 1'b1;
    row_bad     = 1'b0;
    cur_width   = WIDTH_W'(1);
    cur_height  = HEIGHT_W'(1);
    cur_bpp     = BPP_W'(4);
  endfunction

  // row length in bytes as the block sees it with the current registers
  function automatic int unsigned row_bytes();
    int unsigned bpp;
    int unsigned wid;
    int unsigned len;
    bpp = (cur_bpp == 0) ? 1 : (cur_bpp > 4) ? 4 : cur_bpp;
    wid = (cur_width == 0) ? 1 : cur_width;
    len = wid * bpp;
    return (len > LINE_BYTES) ? LINE_BYTES : len;
  endfunction

  // reconstruct one accepted stream word, queue the pixel it yields
  function automatic void unfilter_word(logic [7:0] x);
    int unsigned bpp;
    int unsigned hgt;
    int unsigned len;
    int unsigned col;
    int          i;
    logic [7:0]  a;
    logic [7:0]  b;
    logic [7:0]  c;
    logic [7:0]  pred;
    logic [7:0]  val;
    logic        last_b;
    logic        last_r;
    words_in++;
    if (want_filter) begin
      if (x > FILT_MAX_CODE) begin
        row_kind = FILT_NONE;
        row_bad  = 1'b1;
        bad_rows++;
      end else begin
        row_kind = filter_e'(x[2:0]);
        row_bad  = 1'b0;
      end
      want_filter = 1'b0;
      col_pos     = 0;
      return;
    end
    bpp = (cur_bpp == 0) ? 1 : (cur_bpp > 4) ? 4 : cur_bpp;
    hgt = (cur_height == 0) ? 1 : cur_height;
    len = row_bytes();
    col = (col_pos >= len) ? len - 1 : col_pos;
    a = (col >= bpp) ? recent_px[bpp-1] : 8'd0;
    c = (col >= bpp && row_pos != 0) ? recent_up[bpp-1] : 8'd0;
    b = (row_pos != 0) ? row_above[col] : 8'd0;
    case (row_kind)
      FILT_SUB:   pred = a;
      FILT_UP:    pred = b;
      FILT_AVG:   pred = 8'(({1'b0, a} + {1'b0, b}) >> 1);
      FILT_PAETH: pred = paeth_pick(a, b, c);
      default:    pred = 8'd0;
    endcase
    val = x + pred;
    for (i = 3; i > 0; i--) begin
      recent_px[i] = recent_px[i-1];
      recent_up[i] = recent_up[i-1];
    end
    recent_px[0]   = val;
    recent_up[0]   = b;
    row_above[col] = val;
    last_b = (col_pos + 1 >= len);
    last_r = last_b && (row_pos + 1 >= hgt);
    pending_pixels.push_back('{pixel: val, row_end: last_b, image_end: last_r, bad: row_bad});
    if (last_b) begin
      col_pos     = 0;
      want_filter = 1'b1;
      row_pos     = last_r ? 0 : ((row_pos + 1) & 32'hFFFF);
      rows_done++;
      if (last_r) images_done++;
    end else begin
      col_pos++;
    end
  endfunction

  function automatic void flag_error(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  // offer one stream word, optionally after a short gap, and wait for acceptance
  task automatic send_word(logic [7:0] b);
    if (sender_idles && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk);
    end
    in_valid    <= 1'b1;
    stream_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    unfilter_word(b);
    @(negedge clk);
  endtask

  // filter word, then random data words until the row closes
  task automatic send_row(logic [7:0] filt);
    send_word(filt);
    while (!want_filter) send_word(8'($urandom_range(255)));
  endtask

  // stop offering and let every queued pixel come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_IMAGE_WIDTH:     cur_width  = val[WIDTH_W-1:0];
      REG_IMAGE_HEIGHT:    cur_height = val[HEIGHT_W-1:0];
      REG_BYTES_PER_PIXEL: cur_bpp    = val[BPP_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_config(int unsigned wid, int unsigned hgt, int unsigned bpp);
    wait_drained();
    write_reg(REG_IMAGE_WIDTH, CFG_W'(wid));
    write_reg(REG_IMAGE_HEIGHT, CFG_W'(hgt));
    write_reg(REG_BYTES_PER_PIXEL, CFG_W'(bpp));
  endtask

  // reset registers: one 4-byte pixel per image; second image must not read the store
  task automatic test_reset_defaults();
    send_word({5'b0, FILT_SUB});
    send_word(8'hFF);
    send_word(8'h00);
    send_word(8'h80);
    send_word(8'h7F);
    send_word({5'b0, FILT_UP});
    repeat (4) send_word(8'($urandom_range(255)));
  endtask

  // every filter kind plus an unknown type, with edge data values
  task automatic test_filter_kinds();
    logic [7:0] filt_seq [6];
    logic [7:0] data_seq [12];
    int         r;
    filt_seq = '{{5'b0, FILT_NONE}, {5'b0, FILT_SUB}, {5'b0, FILT_UP},
                 {5'b0, FILT_AVG}, {5'b0, FILT_PAETH}, FILT_MAX_CODE + 8'd1};
    data_seq = '{8'hFF, 8'h01, 8'h80, 8'h7F, 8'h00, 8'hFF,
                 8'hFF, 8'hFF, 8'h12, 8'hEE, 8'h55, 8'hAA};
    set_config(2, 6, 1);
    for (r = 0; r < 6; r++) begin
      send_word(filt_seq[r]);
      send_word(data_seq[2*r]);
      send_word(data_seq[2*r+1]);
    end
  endtask

  // zero width and height, pixel size zero and above four
  task automatic test_odd_registers();
    set_config(0, 0, 0);
    send_word({5'b0, FILT_AVG});
    send_word(8'hFF);
    send_word({5'b0, FILT_PAETH});
    send_word(8'h01);
    set_config(1, 0, 7);
    send_row({5'b0, FILT_SUB});
    set_config(2, 2, 5);
    send_row({5'b0, FILT_SUB});
    send_row({5'b0, FILT_PAETH});
  endtask

  // shrink width and height while a row is open
  task automatic test_mid_row_change();
    int i;
    set_config(8, 3, 1);
    send_word({5'b0, FILT_SUB});
    for (i = 0; i < 5; i++) send_word(8'($urandom_range(255)));
    wait_drained();
    write_reg(REG_IMAGE_WIDTH, CFG_W'(2));
    send_word(8'h3C);
    send_word({5'b0, FILT_UP});
    send_word(8'hC3);
    wait_drained();
    write_reg(REG_IMAGE_HEIGHT, CFG_W'(1));
    send_word(8'h99);
  endtask

  // wider rows that reach far into the line store, the second reading it back
  task automatic test_long_rows();
    set_config(48, 2, 4);
    send_row({5'b0, FILT_SUB});
    send_row({5'b0, FILT_PAETH});
    set_config(50, 1, 3);
    send_row({5'b0, FILT_AVG});
  endtask

  // receiver holds off long enough for the input to back up
  task automatic test_output_stall();
    set_config(16, 4, 3);
    sender_idles = 1'b0;
    rx_hold_req  = 1'b1;
    repeat (2) send_row({5'b0, FILT_UP});
    sender_idles = 1'b1;
    wait_drained();
  endtask

  // random images with random sizes and filters, now and then a height change mid-image
  task automatic test_random_images();
    int unsigned stop_at;
    int unsigned wid;
    int unsigned hgt;
    int unsigned bpp;
    int unsigned pick;
    logic [7:0]  filt;
    stop_at = words_in + RANDOM_WORDS;
    while (words_in < stop_at) begin
      // quiet stretch with no idling on either side
      if (words_in > stop_at - RANDOM_WORDS * 2 / 3 && words_in < stop_at - RANDOM_WORDS / 3) begin
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
      end else begin
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
      end
      pick = $urandom_range(99);
      wid  = (pick < 70) ? $urandom_range(8, 1) :
             (pick < 95) ? $urandom_range(32, 9) : $urandom_range(64, 33);
      hgt  = ($urandom_range(19) == 0) ? 0 : $urandom_range(4, 1);
      bpp  = ($urandom_range(99) < 85) ? $urandom_range(4, 1) : $urandom_range(7);
      set_config(wid, hgt, bpp);
      do begin
        filt = ($urandom_range(99) < 85) ? 8'($urandom_range(4)) : 8'($urandom_range(255));
        send_row(filt);
        if (row_pos != 0 && $urandom_range(9) == 0) begin
          wait_drained();
          write_reg(REG_IMAGE_HEIGHT, CFG_W'($urandom_range(4)));
        end
      end while (row_pos != 0);
    end
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
  endtask

  // receiver: random stalls, or a long hold when asked
  always @(negedge clk) begin
    if (rx_hold_req) begin
      rx_hold_req  = 1'b0;
      rx_hold_left = RX_HOLD_CYCLES;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left = rx_hold_left - 1;
      out_ready   <= 1'b0;
    end else begin
      out_ready <= !(receiver_idles && $urandom_range(99) < 22);
    end
  end

  // compare every delivered pixel against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got_word = {pixel_byte, row_end, image_end, bad_filter};
      if (pending_pixels.size() == 0) begin
        flag_error($sformatf("unexpected word: pixel %02h row_end %0b image_end %0b bad %0b",
                             pixel_byte, row_end, image_end, bad_filter));
      end else begin
        want_word = pending_pixels.pop_front();
        pixels_checked++;
        if (got_word !== want_word) begin
          flag_error($sformatf({"word %0d: expected pixel %02h row_end %0b image_end %0b ",
                                "bad %0b, got pixel %02h row_end %0b image_end %0b bad %0b"},
                               pixels_checked, want_word.pixel, want_word.row_end,
                               want_word.image_end, want_word.bad, got_word.pixel,
                               got_word.row_end, got_word.image_end, got_word.bad));
        end
      end
    end
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("timeout with %0d pixels outstanding", pending_pixels.size());
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_idx     = REG_IMAGE_WIDTH;
    cfg_data    = '0;
    in_valid    = 1'b0;
    stream_byte = 8'd0;
    clear_unfilter_state();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_filter_kinds();
    test_odd_registers();
    test_mid_row_change();
    test_output_stall();
    test_long_rows();
    test_random_images();
    wait_drained();

    $display("covered %0d stream words, %0d pixels checked, %0d rows, %0d images",
             words_in, pixels_checked, rows_done, images_done);
    $display("%0d rows with unknown filter type, %0d mismatches", bad_rows, mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
